@@ hw/rtl/dss_pkg.sv @@
// Package for the unique-key record store with lowest-price listing.
// Holds status codes, the listing limit and the sequencer state type; no dependencies.
package dss_pkg;
	// Most listed records one finish may emit.
	localparam int MAX_OUT = 32;

	typedef enum logic [2:0] {
		ST_ADDED  = 3'd0,
		ST_DUP    = 3'd1,
		ST_FULL   = 3'd2,
		ST_LISTED = 3'd3,
		ST_EMPTY  = 3'd4
	} status_t;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_SCAN  = 7'b0000010,
		S_MIN   = 7'b0000100,
		S_SEL   = 7'b0001000,
		S_EMIT  = 7'b0010000,
		S_WRITE = 7'b0100000,
		S_WAIT  = 7'b1000000
	} state_t;
endpackage

@@ hw/rtl/dss_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module dss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
	input  logic [WIDTH-1:0]                       wdata,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

@@ hw/rtl/dedup_store_min_select_sort.sv @@
// Top level of the unique-key record store; uses dss_pkg and dss_ram.
// Key, price and (quantity, slot) compares walk the store under a small sequencer.
//
// Start is taken at a rising edge where busy is low. An insert walks every
// stored record once, comparing keys, then writes the record in S_WRITE or
// settles in S_WAIT; the single status transfer shows in the last busy cycle.
// A finish on an empty store answers with one status transfer in the cycle
// after the accepting edge and never raises busy. Any other finish walks the
// store once to find the lowest price, then repeatedly walks it to pick the
// record at that price with the smallest (quantity, slot) above the one last
// picked, and fetches each picked record in S_EMIT. A picked record is only
// sent after the following walk, so that walk tells whether it is the final
// one; the final transfer of a finish shows in the first cycle after busy
// falls. The walks follow from the single read port of each record memory.
// Results appear for one cycle with valid high and cannot be stalled by the
// receiver; last marks the final transfer of each item. A finish empties the
// store.
module dedup_store_min_select_sort #(
	parameter int DEPTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  logic         mode,
	input  logic [63:0]  code,
	input  logic [31:0]  price,
	input  logic signed [31:0] quantity,
	output logic         valid,
	output logic [2:0]   status,
	output logic [63:0]  out_code,
	output logic [31:0]  out_price,
	output logic signed [31:0] out_quantity,
	output logic [4:0]   arrival_slot,
	output logic         last
);
	import dss_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	// Walk counters run up to DEPTH+1.
	localparam int CW = $clog2(DEPTH + 2);

	state_t state_q;
	logic [CW-1:0] fill_q, idx_q, rd_q;
	logic [63:0] code_q;
	logic [31:0] price_q, qty_q;
	logic dup_q;
	logic [31:0] minp_q;
	// Last picked (quantity, slot); prev_v_q is low before the first pick.
	// While it is high, the picked record waits on the output ports.
	logic prev_v_q;
	logic signed [31:0] pq_q;
	logic [CW-1:0] ps_q;
	// Best candidate of the current walk.
	logic best_v_q;
	logic signed [31:0] bq_q;
	logic [CW-1:0] bs_q;
	logic [5:0] emitted_q;

	logic we;
	logic [AW-1:0] addr;
	logic [63:0] rk;
	logic [31:0] rp, rq;

	// The record read last cycle sits at slot rd_q.
	logic rd_live;
	assign rd_live = (rd_q < fill_q);

	always_comb begin
		addr = idx_q[AW-1:0];
		we = 1'b0;
		if (state_q == S_WRITE) begin
			addr = fill_q[AW-1:0];
			we = 1'b1;
		end
	end

	dss_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_key (
		.clk(clk), .we(we), .addr(addr), .wdata(code_q), .rdata(rk));
	dss_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_price (
		.clk(clk), .we(we), .addr(addr), .wdata(price_q), .rdata(rp));
	dss_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_qty (
		.clk(clk), .we(we), .addr(addr), .wdata(qty_q), .rdata(rq));

	// Selection compare: is the record read now strictly after prev and
	// strictly before best in (quantity, slot) order.
	logic signed [31:0] cq;
	logic after_prev, before_best, cand;
	always_comb begin
		cq = $signed(rq);
		after_prev = !prev_v_q || (cq > pq_q) || (cq == pq_q && rd_q > ps_q);
		before_best = !best_v_q || (cq < bq_q);
		cand = rd_live && (rp == minp_q) && after_prev && before_best;
	end

	// The waiting record is final when this walk found nothing more or the
	// listing limit is reached.
	logic list_done;
	assign list_done = !best_v_q || (emitted_q == 6'(MAX_OUT - 1));

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q <= '0;
			idx_q <= '0;
			rd_q <= '0;
			code_q <= '0;
			price_q <= '0;
			qty_q <= '0;
			dup_q <= 1'b0;
			minp_q <= '0;
			prev_v_q <= 1'b0;
			pq_q <= '0;
			ps_q <= '0;
			best_v_q <= 1'b0;
			bq_q <= '0;
			bs_q <= '0;
			emitted_q <= '0;
			valid <= 1'b0;
			status <= ST_ADDED;
			out_code <= '0;
			out_price <= '0;
			out_quantity <= '0;
			arrival_slot <= '0;
			last <= 1'b0;
		end else begin
			valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						code_q <= code;
						price_q <= price;
						qty_q <= quantity;
						dup_q <= 1'b0;
						idx_q <= '0;
						rd_q <= CW'(DEPTH);
						prev_v_q <= 1'b0;
						best_v_q <= 1'b0;
						emitted_q <= '0;
						if (mode && fill_q == '0) begin
							valid <= 1'b1;
							status <= ST_EMPTY;
							out_code <= '0;
							out_price <= '0;
							out_quantity <= '0;
							arrival_slot <= '0;
							last <= 1'b1;
						end else if (mode) begin
							state_q <= S_MIN;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (idx_q <= fill_q) begin
						if (rd_live && rk == code_q) begin
							dup_q <= 1'b1;
						end
						rd_q <= idx_q;
						idx_q <= idx_q + 1'b1;
					end else begin
						// Every stored key has been compared by now.
						valid <= 1'b1;
						out_code <= '0;
						out_price <= '0;
						out_quantity <= '0;
						last <= 1'b1;
						if (dup_q) begin
							status <= ST_DUP;
							arrival_slot <= '0;
							state_q <= S_WAIT;
						end else if (fill_q >= CW'(DEPTH)) begin
							status <= ST_FULL;
							arrival_slot <= '0;
							state_q <= S_WAIT;
						end else begin
							status <= ST_ADDED;
							arrival_slot <= 5'(fill_q);
							state_q <= S_WRITE;
						end
					end
				end
				S_WRITE: begin
					fill_q <= fill_q + 1'b1;
					state_q <= S_IDLE;
				end
				S_WAIT: begin
					state_q <= S_IDLE;
				end
				S_MIN: begin
					if (idx_q <= fill_q) begin
						if (rd_live && (rd_q == '0 || rp < minp_q)) begin
							minp_q <= rp;
						end
						rd_q <= idx_q;
						idx_q <= idx_q + 1'b1;
					end else begin
						idx_q <= '0;
						rd_q <= CW'(DEPTH);
						state_q <= S_SEL;
					end
				end
				S_SEL: begin
					if (idx_q <= fill_q) begin
						if (cand) begin
							best_v_q <= 1'b1;
							bq_q <= cq;
							bs_q <= rd_q;
						end
						rd_q <= idx_q;
						idx_q <= idx_q + 1'b1;
					end else begin
						// Send the record picked by the previous walk, now
						// that this walk tells whether another one follows.
						if (prev_v_q) begin
							valid <= 1'b1;
							last <= list_done;
							emitted_q <= emitted_q + 1'b1;
						end
						if (!best_v_q || (prev_v_q && list_done)) begin
							state_q <= S_IDLE;
							fill_q <= '0;
						end else begin
							idx_q <= bs_q;
							rd_q <= CW'(DEPTH);
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					// The chosen slot is read first; the record is loaded onto the output
					// ports in the cycle after, where it waits for the next walk.
					if (rd_q == idx_q) begin
						prev_v_q <= 1'b1;
						pq_q <= bq_q;
						ps_q <= bs_q;
						best_v_q <= 1'b0;
						status <= ST_LISTED;
						out_code <= rk;
						out_price <= rp;
						out_quantity <= $signed(rq);
						arrival_slot <= 5'(idx_q);
						state_q <= S_SEL;
						idx_q <= '0;
						rd_q <= CW'(DEPTH);
					end else begin
						rd_q <= idx_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ hw/rtl/dss_checker.sv @@
// Port-level checker for dedup_store_min_select_sort, bound to the top level.
// Uses the status codes of dss_pkg.
module dss_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       valid,
	input logic [2:0] status,
	input logic       last
);
	import dss_pkg::*;

	a_ins: assert property (@(posedge clk) disable iff (!arst_n)
		valid && status != ST_LISTED |-> last) else $error("single result without last");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> valid || busy) else $error("accepted item lost");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> status <= ST_EMPTY) else $error("bad status");
endmodule

bind dedup_store_min_select_sort dss_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.valid(valid), .status(status), .last(last));
